// ----- rtl/skjd_pkg.sv -----
package skjd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 10;
  localparam int NCNT_W    = 4;

  localparam logic [PIX_W-1:0] PIXEL_SET = 8'd255;
  localparam int MIN_SIZE     = 3;
  localparam int MIN_NEIGHBOURS = 3;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // output queue depth: covers the request in flight plus one stalled result
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] junction_col;
    logic [COORD_W-1:0] junction_row;
    logic [NCNT_W-1:0]  neighbour_count;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } win_res_t;

  function automatic logic [NCNT_W-1:0] count8(input logic [7:0] v);
    logic [NCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + NCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- rtl/skjd_if.sv -----
interface skjd_in_if;
  import skjd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface skjd_out_if;
  import skjd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] junction_col;
  logic [COORD_W-1:0] junction_row;
  logic [NCNT_W-1:0]  neighbour_count;

  modport source (output valid, output junction_col, output junction_row,
                  output neighbour_count, input ready);
  modport sink   (input valid, input junction_col, input junction_row,
                  input neighbour_count, output ready);
endinterface

// ----- rtl/skjd_line_mem.sv -----
module skjd_line_mem #(
  parameter int DEPTH = skjd_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [1:0]               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_data
);
  // bit 1: row r-2, bit 0: row r-1
  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/skjd_window.sv -----
module skjd_window #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid,
  input  logic               top,
  input  logic               mid,
  input  logic               bot,
  input  logic [CW-1:0]      col,
  input  logic [RW-1:0]      row,
  output skjd_pkg::win_res_t res_o
);
  import skjd_pkg::*;

  logic [8:0]        win_r;
  logic [8:0]        win_nxt;
  logic [NCNT_W-1:0] ncount;
  logic [CW-1:0]     col_m1;
  logic [RW-1:0]     row_m1;

  // newest column enters at bits 2..0, centre sits at bit 4
  assign win_nxt = {win_r[5:0], top, mid, bot};
  assign ncount  = count8({win_nxt[8:5], win_nxt[3:0]});
  assign col_m1  = col - CW'(1);
  assign row_m1  = row - RW'(1);

  always_comb begin
    res_o.valid = valid && (col >= CW'(2)) && (row >= RW'(2)) && win_nxt[4]
                  && (ncount >= NCNT_W'(MIN_NEIGHBOURS));
    res_o.res.junction_col    = COORD_W'(col_m1);
    res_o.res.junction_row    = COORD_W'(row_m1);
    res_o.res.neighbour_count = ncount;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (valid) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ----- rtl/skjd_out_fifo.sv -----
module skjd_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  skjd_pkg::win_res_t         push,
  input  logic                       pop,
  output logic                       out_valid,
  output skjd_pkg::res_t             out_res,
  output logic [skjd_pkg::OUT_CNT_W-1:0] count
);
  import skjd_pkg::*;

  res_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] count_r, count_nxt;
  logic                 do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + OUT_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + OUT_PTR_W'(1);
    end
    case ({push.valid, do_pop})
      2'b10:   count_nxt = count_r + OUT_CNT_W'(1);
      2'b01:   count_nxt = count_r - OUT_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.res;
    end
  end

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// ----- rtl/skeleton_junction_detector_core.sv -----
// Skeleton junction detector.
// in_ch carries one pixel of a thinned binary image per request, in raster
// order; a pixel counts as set only at value 255. out_ch carries one request
// per junction: an interior set pixel with three or more set 8-neighbours,
// giving its column, row and neighbour count, in raster order of the centre.
// cfg_we/cfg_index/cfg_wdata set image_width (index 0) and image_height
// (index 1); sizes below 3 act as 3, sizes above MAX_WIDTH/MAX_HEIGHT act as
// those limits. Write them only while the block is idle.
// Throughput: one pixel per clock while the result queue has room. Each pixel
// does one read and one write of the line memory (two bits per column), read at
// acceptance and written back the next cycle from the dual-port line memory.
// A junction is found when its lower-right neighbour is accepted: that pixel
// passes the stage-one registers and the window, then enters the result queue.
// Reset: counters and window clear, sizes return to 640 x 480; the line
// memory is not cleared and needs no pass. Images follow back to back.
// When out_ch stalls, a three-entry result queue absorbs results and in_ch
// drops ready only once that queue and the pixel in flight would fill it.
module skeleton_junction_detector_core #(
  parameter int MAX_WIDTH  = skjd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = skjd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  skjd_in_if.sink                          in_ch,
  skjd_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [skjd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skjd_pkg::CFG_W-1:0]       cfg_wdata
);
  import skjd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SW0 = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int SW  = (RW + 1 > SW0) ? RW + 1 : SW0;

  logic [CFG_W-1:0] width_r, height_r;
  logic [SW-1:0]    cfg_w_ext, cfg_h_ext, eff_w, eff_h;

  logic [CW-1:0] col_r, col_nxt, c0;
  logic [RW-1:0] row_r, row_nxt, r0;
  logic [SW-1:0] r_pre, c_inc, r_inc;
  logic          wrap_col;
  logic          accept;
  logic          bot_in;

  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_bot_r;

  logic [1:0]           mem_rd;
  win_res_t             win_res;
  logic                 fifo_valid;
  res_t                 fifo_res;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OUT_CNT_W:0]   in_flight;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_w_ext = SW'(width_r);
  assign cfg_h_ext = SW'(height_r);
  assign eff_w = (cfg_w_ext < SW'(MIN_SIZE)) ? SW'(MIN_SIZE) :
                 (cfg_w_ext > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : cfg_w_ext;
  assign eff_h = (cfg_h_ext < SW'(MIN_SIZE)) ? SW'(MIN_SIZE) :
                 (cfg_h_ext > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : cfg_h_ext;

  // input handshake
  assign in_flight   = (OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(s1_valid_r);
  assign in_ch.ready = (in_flight < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign bot_in      = (in_ch.pixel_value == PIXEL_SET);

  // position of the arriving pixel; a shrunk size starts a new row or image
  always_comb begin
    wrap_col = (SW'(col_r) >= eff_w);
    c0       = wrap_col ? '0 : col_r;
    r_pre    = wrap_col ? SW'(row_r) + SW'(1) : SW'(row_r);
    r0       = (r_pre >= eff_h) ? '0 : RW'(r_pre);
    c_inc    = SW'(c0) + SW'(1);
    r_inc    = SW'(r0) + SW'(1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (accept) begin
      if (c_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (r_inc >= eff_h) ? '0 : RW'(r_inc);
      end else begin
        col_nxt = CW'(c_inc);
        row_nxt = r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= c0;
      s1_row_r <= r0;
      s1_bot_r <= bot_in;
    end
  end

  // read at acceptance, write back the shifted column in the following cycle
  skjd_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c0),
    .rd_data (mem_rd),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data ({mem_rd[0], s1_bot_r})
  );

  skjd_window #(
    .CW (CW),
    .RW (RW)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .valid (s1_valid_r),
    .top   (mem_rd[1]),
    .mid   (mem_rd[0]),
    .bot   (s1_bot_r),
    .col   (s1_col_r),
    .row   (s1_row_r),
    .res_o (win_res)
  );

  skjd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (win_res),
    .pop       (out_ch.ready),
    .out_valid (fifo_valid),
    .out_res   (fifo_res),
    .count     (fifo_count)
  );

  assign out_ch.valid           = fifo_valid;
  assign out_ch.junction_col    = fifo_res.junction_col;
  assign out_ch.junction_row    = fifo_res.junction_row;
  assign out_ch.neighbour_count = fifo_res.neighbour_count;

  // result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(win_res.valid && (fifo_count == OUT_CNT_W'(OUT_DEPTH)) && !out_ch.ready))
    else $error("result queue overflow");

  // stage one only runs for an accepted pixel
  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(accept))
    else $error("stage one without accepted pixel");

  // every delivered junction has a count in range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.neighbour_count >= NCNT_W'(MIN_NEIGHBOURS))
                     && (out_ch.neighbour_count <= NCNT_W'(8)))
    else $error("neighbour count out of range");

  // stored column stays within the effective width after a pixel
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (SW'(col_r) < eff_w))
    else $error("column counter beyond width");

endmodule

// ----- bench/skeleton_junction_detector_core_tb.sv -----
`timescale 1ns / 100ps

module skeleton_junction_detector_core_tb;
  import skjd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int MAX_GAP = 13;
  localparam int CENTRE_BIT = 4;
  localparam logic [8:0] NEIGHBOUR_MASK = 9'h1EF;

  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_NO_JUNCTION,
    CHECK_JUNCTION
  } row_check_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    row_check_t       check;
    res_t             want;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  skjd_in_if  pix_if ();
  skjd_out_if res_if ();

  skeleton_junction_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // 3 x 3 images: all set, exactly three set neighbours, centre just below set
  pixel_row_t directed_rows [27] = '{
    '{PIXEL_SET, CHECK_NO_JUNCTION, '0}, '{PIXEL_SET, CHECK_NO_JUNCTION, '0},
    '{PIXEL_SET, CHECK_NO_JUNCTION, '0}, '{PIXEL_SET, CHECK_NO_JUNCTION, '0},
    '{PIXEL_SET, CHECK_NO_JUNCTION, '0}, '{PIXEL_SET, CHECK_NO_JUNCTION, '0},
    '{PIXEL_SET, CHECK_NO_JUNCTION, '0}, '{PIXEL_SET, CHECK_NO_JUNCTION, '0},
    '{PIXEL_SET, CHECK_JUNCTION, '{10'd1, 10'd1, 4'd8}},
    '{8'd255, CHECK_NO_JUNCTION, '0}, '{8'd254, CHECK_NO_JUNCTION, '0},
    '{8'd0, CHECK_NO_JUNCTION, '0},   '{8'd127, CHECK_NO_JUNCTION, '0},
    '{8'd255, CHECK_NO_JUNCTION, '0}, '{8'd255, CHECK_NO_JUNCTION, '0},
    '{8'd1, CHECK_NO_JUNCTION, '0},   '{8'd128, CHECK_NO_JUNCTION, '0},
    '{8'd255, CHECK_JUNCTION, '{10'd1, 10'd1, 4'd3}},
    '{8'd255, CHECK_PREDICTED, '0}, '{8'd255, CHECK_PREDICTED, '0},
    '{8'd255, CHECK_PREDICTED, '0}, '{8'd255, CHECK_PREDICTED, '0},
    '{8'd254, CHECK_PREDICTED, '0}, '{8'd255, CHECK_PREDICTED, '0},
    '{8'd255, CHECK_PREDICTED, '0}, '{8'd255, CHECK_PREDICTED, '0},
    '{8'd255, CHECK_PREDICTED, '0}
  };

  // shadow of the block: sizes, line stores, window and position
  logic [CFG_W-1:0] img_width_shadow;
  logic [CFG_W-1:0] img_height_shadow;
  bit line_above [MAX_W];
  bit line_prev [MAX_W];
  bit above_written [MAX_W];
  bit prev_written [MAX_W];
  logic [8:0] win_bits;
  int unsigned next_col;
  int unsigned next_row;
  bit last_hit;

  res_t pending_junctions [$];
  row_check_t drive_check;
  res_t drive_want;
  bit in_burst;
  bit out_burst;
  int stall_left;
  int quiet_cycles;
  int err_count;

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] raw, input int unsigned hi);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic bit step_skeleton(input logic [PIX_W-1:0] pix, output res_t found);
    int unsigned w, h, c, r, n;
    bit top, mid, bot, hit;
    w = eff_size(img_width_shadow, MAX_W);
    h = eff_size(img_height_shadow, MAX_H);
    found = '0;
    hit = 1'b0;
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;
    bot = (pix == PIXEL_SET);
    top = line_above[c];
    mid = line_prev[c];
    line_above[c] = mid;
    above_written[c] = prev_written[c];
    line_prev[c] = bot;
    prev_written[c] = 1'b1;
    win_bits = {win_bits[5:0], top, mid, bot};
    if (c >= 2 && r >= 2 && win_bits[CENTRE_BIT]) begin
      n = $countones(win_bits & NEIGHBOUR_MASK);
      if (n >= MIN_NEIGHBOURS) begin
        found.junction_col = COORD_W'(c - 1);
        found.junction_row = COORD_W'(r - 1);
        found.neighbour_count = NCNT_W'(n);
        hit = 1'b1;
      end
    end
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
    return hit;
  endfunction

  // a wider row mid-image would read line store entries that were never written
  function automatic bit width_growth_safe(input logic [CFG_W-1:0] w_raw,
                                           input logic [CFG_W-1:0] h_raw);
    int unsigned nw, c, r;
    bit ok;
    nw = eff_size(w_raw, MAX_W);
    c = next_col;
    r = next_row;
    if (c >= nw) begin
      c = 0;
      r++;
    end
    if (r >= eff_size(h_raw, MAX_H)) r = 0;
    ok = (nw <= eff_size(img_width_shadow, MAX_W)) || (r == 0);
    if (!ok) begin
      ok = 1'b1;
      for (int i = 0; i < nw; i++) begin
        if (!above_written[i] || !prev_written[i]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(input int density);
    int k;
    if ($urandom_range(0, 99) < density) return PIXEL_SET;
    k = $urandom_range(0, 9);
    if (k < 6) return '0;
    if (k < 8) return PIX_W'($urandom_range(0, 254));
    return PIXEL_SET ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
  endfunction

  function automatic logic [CFG_W-1:0] rand_size();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return CFG_W'($urandom_range(0, MIN_SIZE - 1));
    if (k < 4) return CFG_W'($urandom_range(13, 40));
    return CFG_W'($urandom_range(MIN_SIZE, 12));
  endfunction

  task automatic report(input string what);
    if (err_count < 100) $display("%0t junction check: %s", $time, what);
    err_count++;
  endtask

  task automatic queue_junction(input res_t j);
    pending_junctions = {pending_junctions, j};
  endtask

  task automatic push(input logic [PIX_W-1:0] pix, input row_check_t check, input res_t want);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_value <= pix;
    drive_check <= check;
    drive_want <= want;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every junction is out and the pipeline is quiet
  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    // push a blank pixel while the last accepted pixel gave a hit
    while (last_hit) begin
      push('0, CHECK_PREDICTED, '0);
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_junctions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int count, input int density);
    if (!width_growth_safe(w, h)) w = img_width_shadow;
    write_sizes(w, h);
    in_burst = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    repeat (count) push(rand_pixel(density), CHECK_PREDICTED, '0);
    drain();
  endtask

  task automatic random_phases(input int target);
    int sent, n;
    sent = 0;
    while (sent < target) begin
      n = $urandom_range(16, 90);
      run_phase(rand_size(), rand_size(), n, $urandom_range(20, 80));
      sent += n;
    end
  endtask

  always @(posedge clk) begin : track
    res_t predicted, want;
    bit hit;
    if (!rst_n) begin
      img_width_shadow = WIDTH_RESET;
      img_height_shadow = HEIGHT_RESET;
      for (int i = 0; i < MAX_W; i++) begin
        line_above[i] = 1'b0;
        line_prev[i] = 1'b0;
        above_written[i] = 1'b0;
        prev_written[i] = 1'b0;
      end
      win_bits = '0;
      next_col = 0;
      next_row = 0;
      last_hit = 1'b0;
      pending_junctions.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) img_width_shadow = cfg_wdata;
        else img_height_shadow = cfg_wdata;
      end
      if (pix_if.valid && pix_if.ready) begin
        hit = step_skeleton(pix_if.pixel_value, predicted);
        last_hit = hit;
        if (drive_check == CHECK_JUNCTION) queue_junction(drive_want);
        else if (drive_check == CHECK_PREDICTED && hit) queue_junction(predicted);
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_junctions.size() == 0) begin
          report($sformatf("unexpected junction col %0d row %0d count %0d",
                           res_if.junction_col, res_if.junction_row, res_if.neighbour_count));
        end else begin
          want = pending_junctions.pop_front();
          if (res_if.junction_col !== want.junction_col)
            report($sformatf("junction_col %0d, want %0d", res_if.junction_col,
                             want.junction_col));
          if (res_if.junction_row !== want.junction_row)
            report($sformatf("junction_row %0d, want %0d", res_if.junction_row,
                             want.junction_row));
          if (res_if.neighbour_count !== want.neighbour_count)
            report($sformatf("neighbour_count %0d, want %0d at col %0d row %0d",
                             res_if.neighbour_count, want.neighbour_count,
                             want.junction_col, want.junction_row));
        end
      end
    end
  end

  // result side: after a request, stall for a drawn number of cycles (none in burst phases)
  always @(posedge clk) begin : result_sink
    int n;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (res_if.ready && res_if.valid) begin
      n = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (n != 0) begin
        res_if.ready <= 1'b0;
        stall_left <= n - 1;
      end
    end else if (!res_if.ready) begin
      if (stall_left == 0) res_if.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("skeleton_junction_detector_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    pix_if.valid = 1'b0;
    pix_if.pixel_value = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    drive_check = CHECK_PREDICTED;
    drive_want = '0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    err_count = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both sizes below the minimum: 3 x 3 images
    write_sizes(11'd0, 11'd1);
    foreach (directed_rows[i])
      push(directed_rows[i].pix, directed_rows[i].check, directed_rows[i].want);
    drain();

    random_phases(260);

    // height above the limit acts as the limit: a tall narrow image
    run_phase(11'd5, 11'd2047, 60, 50);

    random_phases(240);

    if (err_count == 0) begin
      $display("skeleton_junction_detector_core_tb: PASS");
    end else begin
      $display("skeleton_junction_detector_core_tb: FAIL");
    end
    $finish;
  end

endmodule
